// ===== rtl/mono_framebuffer_draw_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome framebuffer draw engine.
// Every macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication check.
`define MFB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mono draw engine check failed");

// Next-cycle implication check.
`define MFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mono draw engine check failed");

`endif

// ===== rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Op codes, control and status bundles and the font ROM for the draw engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // Command op codes.
  localparam logic [3:0] OP_CLEAR   = 4'd0;
  localparam logic [3:0] OP_INVERT  = 4'd1;
  localparam logic [3:0] OP_FILL    = 4'd2;
  localparam logic [3:0] OP_HLINE   = 4'd3;
  localparam logic [3:0] OP_LINE    = 4'd4;
  localparam logic [3:0] OP_OUTLINE = 4'd5;
  localparam logic [3:0] OP_CIRCLE  = 4'd6;
  localparam logic [3:0] OP_GLYPH   = 4'd7;
  localparam logic [3:0] OP_READ    = 4'd8;

  // Memory address select codes.
  localparam logic [1:0] ASEL_SWEEP = 2'd0;
  localparam logic [1:0] ASEL_PIX   = 2'd1;
  localparam logic [1:0] ASEL_READ  = 2'd2;

  // Memory write data select codes.
  localparam logic [1:0] WSEL_ZERO = 2'd0;
  localparam logic [1:0] WSEL_INV  = 2'd1;
  localparam logic [1:0] WSEL_PIX  = 2'd2;

  localparam logic [7:0] DEGREE_CODE = 8'hB0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       sweep_rst;
    logic       sweep_adv;
    logic       pix_adv;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] asel;
    logic [1:0] wsel;
    logic       rd_cap;
    logic       res_load;
  } mfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic       empty;
    logic       pix_on;
    logic       pix_last;
    logic       sweep_last;
    logic       rd_in_range;
  } mfb_stat_t;

  // Shapes are five columns, column 0 in the top byte; bit n of a column is row n.
  localparam logic [39:0] RING_SHAPE = 40'h0E_11_11_11_0E;
  localparam logic [39:0] DISC_SHAPE = 40'h0E_1F_1F_1F_0E;

  localparam logic [39:0] FONT_DIGITS [10] = '{
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E
  };

  localparam logic [39:0] FONT_CAPS [26] = '{
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
    40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
    40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  localparam logic [39:0] FONT_SMALLS [26] = '{
    40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20, 40'h38_44_44_48_7F,
    40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E, 40'h7F_08_04_04_78,
    40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00, 40'h00_41_7F_40_00,
    40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38, 40'h7C_14_14_14_08,
    40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20, 40'h04_3F_44_40_20,
    40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C, 40'h44_28_10_28_44,
    40'h0C_50_50_50_3C, 40'h44_64_54_4C_44
  };

  // Glyph lookup: digits, capitals, small letters, a few symbols, else blank.
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] g;
    g = 40'h0;
    if (code >= 8'h30 && code <= 8'h39) begin
      g = FONT_DIGITS[4'(code - 8'h30)];
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      g = FONT_CAPS[5'(code - 8'h41)];
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      g = FONT_SMALLS[5'(code - 8'h61)];
    end else begin
      case (code)
        8'h2D:       g = 40'h08_08_08_08_08;
        8'h2E:       g = 40'h00_00_00_60_60;
        8'h3A:       g = 40'h00_36_36_00_00;
        8'h25:       g = 40'h63_13_08_64_63;
        8'h2F:       g = 40'h40_30_0C_03_00;
        8'h21:       g = 40'h00_00_5F_00_00;
        8'h2C:       g = 40'h00_50_30_00_00;
        DEGREE_CODE: g = 40'h06_09_09_06_00;
        default:     g = 40'h0;
      endcase
    end
    return g;
  endfunction

endpackage

// ===== rtl/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// Sequencer for the draw engine: sweeps, per-pixel read-modify-write, reads.
// ----------------------------------------------------------------------------
module mfb_ctrl
  import mfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mfb_stat_t stat,
  output mfb_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_INV_RD = 4'd3;
  localparam logic [3:0] S_INV_WR = 4'd4;
  localparam logic [3:0] S_PIX    = 4'd5;
  localparam logic [3:0] S_PIX_WR = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_RD_CAP = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state, state_next;
  logic       boot, boot_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    boot_next  = boot;
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        unique case (stat.op) inside
          OP_CLEAR: begin
            cmd.sweep_rst = 1'b1;
            state_next    = S_CLR;
          end
          OP_INVERT: begin
            cmd.sweep_rst = 1'b1;
            state_next    = S_INV_RD;
          end
          OP_FILL, OP_HLINE, OP_OUTLINE, OP_CIRCLE, OP_GLYPH: begin
            state_next = stat.empty ? S_FIN : S_PIX;
          end
          OP_LINE: state_next = S_PIX;
          OP_READ: state_next = stat.rd_in_range ? S_RD : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_CLR: begin
        cmd.asel      = ASEL_SWEEP;
        cmd.wsel      = WSEL_ZERO;
        cmd.mem_wr    = 1'b1;
        cmd.sweep_adv = 1'b1;
        if (stat.sweep_last) begin
          boot_next  = 1'b0;
          state_next = boot ? S_IDLE : S_FIN;
        end
      end
      S_INV_RD: begin
        cmd.asel   = ASEL_SWEEP;
        cmd.mem_rd = 1'b1;
        state_next = S_INV_WR;
      end
      S_INV_WR: begin
        cmd.asel      = ASEL_SWEEP;
        cmd.wsel      = WSEL_INV;
        cmd.mem_wr    = 1'b1;
        cmd.sweep_adv = 1'b1;
        state_next    = stat.sweep_last ? S_FIN : S_INV_RD;
      end
      S_PIX: begin
        cmd.asel = ASEL_PIX;
        if (stat.pix_on) begin
          cmd.mem_rd = 1'b1;
          state_next = S_PIX_WR;
        end else begin
          cmd.pix_adv = 1'b1;
          if (stat.pix_last) state_next = S_FIN;
        end
      end
      S_PIX_WR: begin
        cmd.asel    = ASEL_PIX;
        cmd.wsel    = WSEL_PIX;
        cmd.mem_wr  = 1'b1;
        cmd.pix_adv = 1'b1;
        state_next  = stat.pix_last ? S_FIN : S_PIX;
      end
      S_RD: begin
        cmd.asel   = ASEL_READ;
        cmd.mem_rd = 1'b1;
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result beat is held until it is taken.
  assign out_valid_next = (out_valid && !out_ready) || cmd.res_load;

  // State registers; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      boot      <= boot_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/mfb_dp.sv =====
// ----------------------------------------------------------------------------
// mfb_dp
// Datapath: command registers, pixel walker, Bresenham stepper and pixel store.
// ----------------------------------------------------------------------------
module mfb_dp
  import mfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  mfb_cmd_t           cmd,
  output mfb_stat_t          stat,
  input  logic        [3:0]  op,
  input  logic signed [15:0] x_a,
  input  logic signed [15:0] y_a,
  input  logic signed [15:0] x_b,
  input  logic signed [15:0] y_b,
  input  logic        [7:0]  width,
  input  logic        [7:0]  height,
  input  logic               invert,
  input  logic               filled,
  input  logic        [7:0]  char_code,
  input  logic        [9:0]  read_index,
  output logic        [7:0]  read_data
);

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic signed [17:0] W_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S = 18'(SCREEN_HEIGHT);

  logic        [3:0]  op_r;
  logic               inv_r;
  logic signed [17:0] x0, y0;
  logic        [7:0]  wlim, hlim, c, r;
  logic        [39:0] shape;
  logic signed [17:0] lx, ly, ex, ey, dx, dy;
  logic               sx_neg, sy_neg;
  logic signed [19:0] err;
  logic        [9:0]  ridx;
  logic        [7:0]  res_byte;
  logic        [AW-1:0] sweep;
  logic        [7:0]  mem [STORE_BYTES];
  logic        [7:0]  rdata;

  logic               is_line, is_outline;
  logic signed [17:0] pix_x, pix_y;
  logic        [AW-1:0] pix_addr, addr;
  logic               shape_bit, pix_val;
  logic        [7:0]  mask, wdata;
  logic signed [17:0] ld_ddx, ld_ddy, ld_dx, ld_dy;
  logic signed [20:0] e2;
  logic               step_x, step_y;
  logic               row_end, interior;

  assign is_line    = (op_r == OP_LINE);
  assign is_outline = (op_r == OP_OUTLINE);

  // Current pixel position.
  assign pix_x = is_line ? lx : x0 + $signed({10'b0, c});
  assign pix_y = is_line ? ly : y0 + $signed({10'b0, r});

  assign pix_addr = AW'(32'(pix_y[7:3]) * SCREEN_WIDTH + 32'(pix_x[7:0]));

  // Pixel value by op.
  assign shape_bit = (c < 8'd5) && (r < 8'd7) && shape[8 * (4 - c[2:0]) + r[2:0]];
  always_comb begin
    case (op_r) inside
      OP_FILL, OP_OUTLINE:  pix_val = !inv_r;
      OP_CIRCLE, OP_GLYPH:  pix_val = shape_bit ^ inv_r;
      default:              pix_val = 1'b1;
    endcase
  end

  // Status toward the controller.
  assign row_end  = (c == 8'(wlim - 8'd1));
  assign interior = (r != 8'd0) && (r != 8'(hlim - 8'd1));
  always_comb begin
    stat.op          = op_r;
    stat.empty       = (wlim == 8'd0) || (hlim == 8'd0);
    stat.pix_on      = (pix_x >= 0) && (pix_x < W_S) && (pix_y >= 0) && (pix_y < H_S);
    stat.pix_last    = is_line ? ((lx == ex) && (ly == ey))
                               : (row_end && (r == 8'(hlim - 8'd1)));
    stat.sweep_last  = (sweep == AW'(STORE_BYTES - 1));
    stat.rd_in_range = (32'(ridx) < STORE_BYTES);
  end

  // Line setup from the raw endpoints.
  assign ld_ddx = 18'(x_b) - 18'(x_a);
  assign ld_ddy = 18'(y_b) - 18'(y_a);
  assign ld_dx  = ld_ddx[17] ? -ld_ddx : ld_ddx;
  assign ld_dy  = ld_ddy[17] ? ld_ddy : -ld_ddy;

  // Bresenham step decisions.
  assign e2     = 21'(err) <<< 1;
  assign step_x = (e2 >= 21'(dy));
  assign step_y = (e2 <= 21'(dx));

  // Command capture and pixel walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      inv_r    <= invert;
      ridx     <= read_index;
      res_byte <= 8'd0;
      c        <= 8'd0;
      r        <= 8'd0;
      x0       <= (op == OP_GLYPH) ? 18'(x_a) : {10'b0, x_a[7:0]};
      y0       <= {10'b0, y_a[7:0]};
      shape    <= (op == OP_CIRCLE) ? (filled ? DISC_SHAPE : RING_SHAPE)
                                    : glyph_bits(char_code);
      case (op)
        OP_CIRCLE: begin
          wlim <= 8'd5;
          hlim <= 8'd5;
        end
        OP_GLYPH: begin
          wlim <= 8'd6;
          hlim <= 8'd8;
        end
        OP_HLINE: begin
          wlim <= width;
          hlim <= 8'd1;
        end
        default: begin
          wlim <= width;
          hlim <= height;
        end
      endcase
      lx     <= 18'(x_a);
      ly     <= 18'(y_a);
      ex     <= 18'(x_b);
      ey     <= 18'(y_b);
      dx     <= ld_dx;
      dy     <= ld_dy;
      sx_neg <= !(x_a < x_b);
      sy_neg <= !(y_a < y_b);
      err    <= 20'(ld_dx) + 20'(ld_dy);
    end else begin
      if (cmd.pix_adv) begin
        if (is_line) begin
          err <= err + (step_x ? 20'(dy) : 20'sd0) + (step_y ? 20'(dx) : 20'sd0);
          if (step_x) lx <= sx_neg ? lx - 18'sd1 : lx + 18'sd1;
          if (step_y) ly <= sy_neg ? ly - 18'sd1 : ly + 18'sd1;
        end else if (row_end) begin
          c <= 8'd0;
          r <= r + 8'd1;
        end else if (is_outline && interior && c == 8'd0) begin
          c <= 8'(wlim - 8'd1);
        end else begin
          c <= c + 8'd1;
        end
      end
      if (cmd.rd_cap) res_byte <= rdata;
    end
  end

  // Sweep counter for clear and invert passes.
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_rst) begin
      sweep <= '0;
    end else if (cmd.sweep_adv) begin
      sweep <= stat.sweep_last ? '0 : sweep + AW'(1);
    end
  end

  // Memory address and write data.
  assign mask = 8'(1) << pix_y[2:0];
  always_comb begin
    case (cmd.asel)
      ASEL_PIX:  addr = pix_addr;
      ASEL_READ: addr = AW'(ridx);
      default:   addr = sweep;
    endcase
    case (cmd.wsel)
      WSEL_INV: wdata = ~rdata;
      WSEL_PIX: wdata = pix_val ? (rdata | mask) : (rdata & ~mask);
      default:  wdata = 8'd0;
    endcase
  end

  // Pixel store.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= wdata;
    if (cmd.mem_rd) rdata <= mem[addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) read_data <= res_byte;
  end

endmodule

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// Clear writes each byte of the store; invert reads and then writes back each byte.
// A pixel op reads and writes each on-screen pixel's byte and skips clipped pixels;
// a read fetches one byte. The store's single read-modify-write port sets the rate.
// One command is in flight at a time; a finished result may wait while the next is taken.
// Reset is synchronous; after it the store is swept to zero, one byte a cycle,
// with in_ready low.
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Drawing engine for a 1-bit page-organized framebuffer.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine
  import mfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [3:0]  op,
  input  logic signed [15:0] x_a,
  input  logic signed [15:0] y_a,
  input  logic signed [15:0] x_b,
  input  logic signed [15:0] y_b,
  input  logic        [7:0]  width,
  input  logic        [7:0]  height,
  input  logic               invert,
  input  logic               filled,
  input  logic        [7:0]  char_code,
  input  logic        [9:0]  read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  read_data
);

  mfb_cmd_t  cmd;
  mfb_stat_t stat;

  // Sequencer.
  mfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath and pixel store.
  mfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .x_a        (x_a),
    .y_a        (y_a),
    .x_b        (x_b),
    .y_b        (y_b),
    .width      (width),
    .height     (height),
    .invert     (invert),
    .filled     (filled),
    .char_code  (char_code),
    .read_index (read_index),
    .read_data  (read_data)
  );

endmodule

// ===== rtl/mfb_checker.sv =====
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level checks for the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_defines.svh"

module mfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data
);

  // A result beat that is not taken holds its value.
  `MFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data))

  // Only one command is worked on at a time.
  `MFB_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // The store is being cleared right after reset, so no command is taken.
  `MFB_ASSERT_IMPL(a_busy_after_reset, $past(rst), !in_ready)

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (.*);

// ===== verif/tb_mono_framebuffer_draw_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine
// Drives draw, clear, invert and read commands into the draw engine. A local
// copy of the pixel store is kept in step with every accepted command, and
// each read_data beat is compared with the value that this copy predicts.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine;
  import mfb_pkg::*;

  localparam int SCR_W      = 128;
  localparam int SCR_H      = 64;
  localparam int FB_BYTES   = SCR_W * ((SCR_H + 7) / 8);
  localparam int MAX_CYCLES = 20_000_000;
  localparam int TAIL_WAIT  = 32;
  localparam int N_RANDOM   = 1500;

  typedef struct {
    logic [3:0]         op;
    logic signed [15:0] xa, ya, xb, yb;
    logic [7:0]         w, h;
    logic               inv, fill;
    logic [7:0]         code;
    logic [9:0]         ridx;
  } draw_cmd_t;

  // Font columns, column 0 in the top byte; bit n of a column is row n.
  localparam logic [39:0] DIGIT_COLS [10] = '{
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E};
  localparam logic [39:0] CAP_COLS [26] = '{
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C, 40'h7F49494941,
    40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
    40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463, 40'h0708700807,
    40'h6151494543};
  localparam logic [39:0] SMALL_COLS [26] = '{
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         op = OP_CLEAR;
  logic signed [15:0] x_a = '0, y_a = '0, x_b = '0, y_b = '0;
  logic [7:0]         width = '0, height = '0;
  logic               invert = 1'b0, filled = 1'b0;
  logic [7:0]         char_code = '0;
  logic [9:0]         read_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         read_data;

  // Predicted pixel store and the read_data bytes still owed by the block.
  logic [7:0] fb_model [FB_BYTES];
  logic [7:0] owed_bytes [$];
  int         n_errors = 0;
  int         n_cmds = 0;
  int         n_beats = 0;
  int         n_reads = 0;
  int         rsp_hold = 0;
  bit         no_idle = 1'b0;
  longint     n_cycles = 0;

  mono_framebuffer_draw_engine #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .x_a       (x_a),
    .y_a       (y_a),
    .x_b       (x_b),
    .y_b       (y_b),
    .width     (width),
    .height    (height),
    .invert    (invert),
    .filled    (filled),
    .char_code (char_code),
    .read_index(read_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
  );

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, n_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void model_dot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
    idx = (y / 8) * SCR_W + x;
    if (on) fb_model[idx] = fb_model[idx] | (8'h01 << (y % 8));
    else fb_model[idx] = fb_model[idx] & ~(8'h01 << (y % 8));
  endfunction

  function automatic logic [39:0] font_columns(logic [7:0] c);
    logic [39:0] g;
    g = '0;
    if (c >= "0" && c <= "9") g = DIGIT_COLS[c - "0"];
    else if (c >= "A" && c <= "Z") g = CAP_COLS[c - "A"];
    else if (c >= "a" && c <= "z") g = SMALL_COLS[c - "a"];
    else if (c == "-") g = 40'h0808080808;
    else if (c == ".") g = 40'h0000006060;
    else if (c == ":") g = 40'h0036360000;
    else if (c == "%") g = 40'h6313086463;
    else if (c == "/") g = 40'h40300C0300;
    else if (c == "!") g = 40'h00005F0000;
    else if (c == ",") g = 40'h0050300000;
    else if (c == DEGREE_CODE) g = 40'h0609090600;
    return g;
  endfunction

  function automatic void walk_line(int x, int y, int ex, int ey);
    int dx, sx, dy, sy, err, e2;
    dx = (ex >= x) ? ex - x : x - ex;
    sx = (x < ex) ? 1 : -1;
    dy = -((ey >= y) ? ey - y : y - ey);
    sy = (y < ey) ? 1 : -1;
    err = dx + dy;
    while (1) begin
      model_dot(x, y, 1'b1);
      if (x == ex && y == ey) break;
      e2 = err * 2;
      if (e2 >= dy) begin
        err += dy;
        x += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  // Applies one command to the model store and returns the expected read_data.
  function automatic logic [7:0] apply_cmd(draw_cmd_t c);
    int          xu, yu, w, h;
    logic [39:0] shape;
    bit          b;
    logic [7:0]  data;
    xu = int'(c.xa[7:0]);
    yu = int'(c.ya[7:0]);
    w = int'(c.w);
    h = int'(c.h);
    data = '0;
    case (c.op)
      OP_CLEAR: foreach (fb_model[i]) fb_model[i] = '0;
      OP_INVERT: foreach (fb_model[i]) fb_model[i] = ~fb_model[i];
      OP_FILL: begin
        for (int r = 0; r < h; r++)
          for (int k = 0; k < w; k++) model_dot(xu + k, yu + r, !c.inv);
      end
      OP_HLINE: for (int k = 0; k < w; k++) model_dot(xu + k, yu, 1'b1);
      OP_LINE: walk_line(int'(c.xa), int'(c.ya), int'(c.xb), int'(c.yb));
      OP_OUTLINE: begin
        if (w != 0 && h != 0) begin
          for (int k = 0; k < w; k++) begin
            model_dot(xu + k, yu, !c.inv);
            if (h > 1) model_dot(xu + k, yu + h - 1, !c.inv);
          end
          for (int k = 1; k + 1 < h; k++) begin
            model_dot(xu, yu + k, !c.inv);
            if (w > 1) model_dot(xu + w - 1, yu + k, !c.inv);
          end
        end
      end
      OP_CIRCLE: begin
        shape = c.fill ? 40'h0E1F1F1F0E : 40'h0E1111110E;
        for (int k = 0; k < 5; k++)
          for (int r = 0; r < 5; r++) begin
            b = shape[39 - 8 * k - 7 + r];
            model_dot(xu + k, yu + r, b ^ c.inv);
          end
      end
      OP_GLYPH: begin
        shape = font_columns(c.code);
        for (int k = 0; k < 6; k++)
          for (int r = 0; r < 8; r++) begin
            b = (k < 5 && r < 7) ? shape[39 - 8 * k - 7 + r] : 1'b0;
            model_dot(int'(c.xa) + k, yu + r, b ^ c.inv);
          end
      end
      OP_READ: if (c.ridx < FB_BYTES) data = fb_model[c.ridx];
      default: ;
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------- result checking
  // Beats are sampled mid-cycle; out_ready only moves at the rising edge.
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_beats++;
      if (owed_bytes.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat, actual read_data=%02h", $time, read_data);
      end else begin
        if (read_data !== owed_bytes[0]) begin
          n_errors++;
          $display("%0t: read_data mismatch, expected=%02h actual=%02h",
                   $time, owed_bytes[0], read_data);
        end
        void'(owed_bytes.pop_front());
      end
    end
  end

  // Result side stalls: a random hold after each beat, none in no_idle phases.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rsp_hold  <= 0;
    end else if (out_ready && out_valid) begin
      rsp_hold  <= no_idle ? 0 : $urandom_range(0, 11);
      out_ready <= no_idle || ($urandom_range(0, 1) == 0);
    end else if (rsp_hold > 0) begin
      rsp_hold  <= rsp_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Sends one command beat; returns at the edge where it was accepted.
  task automatic send_cmd(draw_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= c.op;
    x_a <= c.xa;
    y_a <= c.ya;
    x_b <= c.xb;
    y_b <= c.yb;
    width <= c.w;
    height <= c.h;
    invert <= c.inv;
    filled <= c.fill;
    char_code <= c.code;
    read_index <= c.ridx;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    owed_bytes.push_back(apply_cmd(c));
    n_cmds++;
    if (c.op == OP_READ) n_reads++;
  endtask

  // Holds the sender off until every owed beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  function automatic draw_cmd_t make_cmd(logic [3:0] o, int xa, int ya, int xb, int yb,
                                         int w, int h, bit inv, bit fill, int code,
                                         int ridx);
    draw_cmd_t c;
    c.op = o;
    c.xa = 16'(xa);
    c.ya = 16'(ya);
    c.xb = 16'(xb);
    c.yb = 16'(yb);
    c.w = 8'(w);
    c.h = 8'(h);
    c.inv = inv;
    c.fill = fill;
    c.code = 8'(code);
    c.ridx = 10'(ridx);
    return c;
  endfunction

  function automatic int near_coord(int base);
    int v;
    v = base + $urandom_range(0, 60) - 30;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Mostly small on-screen shapes with random content, some wild coordinates.
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        sel, xa, ya;
    c = make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    c.xb = 16'($urandom());
    c.yb = 16'($urandom());
    c.w = 8'($urandom_range(0, 40));
    c.h = 8'($urandom_range(0, 40));
    c.inv = 1'($urandom_range(0, 1));
    c.fill = 1'($urandom_range(0, 1));
    c.code = ($urandom_range(0, 1) == 0) ? 8'($urandom()) : 8'($urandom_range(33, 122));
    c.ridx = 10'($urandom());
    // Upper bits of byte coordinates are don't-care but still toggled.
    c.xa = {8'($urandom()), 8'($urandom_range(0, 140))};
    c.ya = {8'($urandom()), 8'($urandom_range(0, 72))};
    if ($urandom_range(0, 99) < 3) begin
      c.w = 8'($urandom());
      c.h = 8'($urandom_range(0, 80));
    end
    sel = $urandom_range(0, 99);
    if (sel < 35) c.op = OP_READ;
    else if (sel < 37) c.op = OP_CLEAR;
    else if (sel < 39) c.op = OP_INVERT;
    else if (sel < 46) c.op = OP_FILL;
    else if (sel < 53) c.op = OP_HLINE;
    else if (sel < 66) c.op = OP_LINE;
    else if (sel < 73) c.op = OP_OUTLINE;
    else if (sel < 82) c.op = OP_CIRCLE;
    else if (sel < 96) c.op = OP_GLYPH;
    else c.op = 4'($urandom_range(9, 15));
    if (c.op == OP_LINE || c.op == OP_GLYPH) begin
      if ($urandom_range(0, 7) == 0) begin
        xa = int'($signed(16'($urandom())));
        ya = int'($signed(16'($urandom())));
      end else begin
        xa = $urandom_range(0, 150) - 10;
        ya = $urandom_range(0, 84) - 10;
      end
      c.xa = 16'(xa);
      if (c.op == OP_LINE) begin
        c.ya = 16'(ya);
        c.xb = 16'(near_coord(xa));
        c.yb = 16'(near_coord(ya));
      end
    end
    return c;
  endfunction

  task automatic test_directed();
    no_idle = 1'b0;
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Empty rectangles in both dimensions, then a full-size fill and clear.
    send_cmd(make_cmd(OP_FILL, 3, 3, 0, 0, 0, 9, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_OUTLINE, 3, 3, 0, 0, 9, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_FILL, 16'hFF00, 16'hFF00, 0, 0, 255, 255, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_FILL, 10, 10, 0, 0, 20, 20, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 140));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_HLINE, 255, 255, 0, 0, 255, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_HLINE, 0, 63, 0, 0, 255, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_OUTLINE, 5, 5, 0, 0, 1, 1, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_OUTLINE, 0, 0, 0, 0, 128, 64, 1, 0, 0, 0));
    // Longest possible line, corner to corner of the coordinate space.
    send_cmd(make_cmd(OP_LINE, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_LINE, 127, 0, 0, 63, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_LINE, 40, 40, 40, 40, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CIRCLE, 124, 60, 0, 0, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(OP_CIRCLE, 20, 20, 0, 0, 0, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_GLYPH, -3, 2, 0, 0, 0, 0, 0, 0, DEGREE_CODE, 0));
    send_cmd(make_cmd(OP_GLYPH, 125, 60, 0, 0, 0, 0, 1, 0, 8'h01, 0));
    send_cmd(make_cmd(OP_GLYPH, 50, 8, 0, 0, 0, 0, 0, 0, "W", 0));
    send_cmd(make_cmd(4'd9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5));
    send_cmd(make_cmd(4'd15, -1, -1, -1, -1, 255, 255, 1, 1, 255, 1023));
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < N_RANDOM; i++) begin
      // Every 300 commands, pick at random a phase with or without idle cycles on both sides.
      if (i % 300 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == N_RANDOM / 2) drain_results();
      send_cmd(random_cmd());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_store_readback();
    for (int i = 0; i < FB_BYTES; i += 8)
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, i + $urandom_range(0, 7)));
  endtask

  initial begin
    foreach (fb_model[i]) fb_model[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_store_readback();
    drain_results();
    $display("Ran %0d commands (%0d reads), %0d result beats checked.",
             n_cmds, n_reads, n_beats);
    $display("Covered all draw ops, undefined ops, clipping and random stalls.");
    if (n_errors == 0 && owed_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0t: %0d errors, %0d results missing", $time, n_errors,
               owed_bytes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mfb_pkg.sv
rtl/mfb_ctrl.sv
rtl/mfb_dp.sv
rtl/mono_framebuffer_draw_engine.sv
rtl/mfb_checker.sv
verif/tb_mono_framebuffer_draw_engine.sv
